[hdl/lpht_pkg.sv]
// ----------------------------------------------------------------------------
// lpht_pkg: shared types and constants for the linear probing hash table
// Status codes, operation codes, controller states, command and status
// groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package lpht_pkg;

	// Default number of slots in the store
	localparam int LPHT_CAPACITY = 1024;

	// Fixed field widths
	localparam int KEY_W      = 32;
	localparam int TS_W       = 11;
	localparam int STATUS_W   = 3;
	localparam logic [TS_W-1:0] TS_RESET = TS_W'(11);

	// Hash: seven rounds, result below 2^28
	localparam int HASH_ROUNDS = 7;
	localparam int HASH_W      = 28;
	// Remainder taken four hash bits per cycle
	localparam int MOD_DIGIT   = 4;
	localparam int MOD_STEPS   = HASH_W / MOD_DIGIT;
	localparam int STEP_W      = 3;

	// Operation codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_STORED      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_STORED_COLL = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL        = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FOUND       = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd5;

	// Controller states
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_MOD,
		S_READ,
		S_CHECK,
		S_RESULT
	} lpht_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic clear_step;
		logic load;
		logic hash_step;
		logic mod_step;
		logic rd;
		logic check;
		logic emit;
	} lpht_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic clear_done;
		logic key_zero;
		logic hash_last;
		logic mod_last;
		logic probe_done;
		logic out_free;
	} lpht_stat_t;

endpackage

[hdl/lpht_ctrl.sv]
// ----------------------------------------------------------------------------
// lpht_ctrl: sequencing controller
// Clearing pass after reset, then per request: hash rounds, remainder steps,
// probe read/compare loop, result hand-off; a zero key goes to the result.
// ----------------------------------------------------------------------------
module lpht_ctrl import lpht_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  lpht_stat_t stat,
	output lpht_cmd_t  cmd
);

	lpht_state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (stat.clear_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) state_d = stat.key_zero ? S_RESULT : S_HASH;
			end
			S_HASH: begin
				if (stat.hash_last) state_d = S_MOD;
			end
			S_MOD: begin
				if (stat.mod_last) state_d = S_READ;
			end
			S_READ: begin
				state_d = S_CHECK;
			end
			S_CHECK: begin
				state_d = stat.probe_done ? S_RESULT : S_READ;
			end
			S_RESULT: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	// Outputs
	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			S_CLEAR:  cmd.clear_step = 1'b1;
			S_IDLE: begin
				req_stall = 1'b0;
				cmd.load  = req_valid;
			end
			S_HASH:   cmd.hash_step = 1'b1;
			S_MOD:    cmd.mod_step  = 1'b1;
			S_READ:   cmd.rd        = 1'b1;
			S_CHECK:  cmd.check     = 1'b1;
			S_RESULT: cmd.emit      = stat.out_free;
			default:  cmd           = '0;
		endcase
	end

endmodule

[hdl/lpht_dpath.sv]
// ----------------------------------------------------------------------------
// lpht_dpath: datapath of the hash table
// Size register, key store, hash and remainder unit, probe pointer,
// entry count and result register.
// ----------------------------------------------------------------------------
module lpht_dpath import lpht_pkg::*; #(
	parameter int CAPACITY = LPHT_CAPACITY,
	localparam int SLOT_W  = $clog2(CAPACITY),
	localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lpht_cmd_t               cmd,
	output lpht_stat_t              stat,
	input  logic                    cfg_wen,
	input  logic [TS_W-1:0]         cfg_wdata,
	input  logic                    operation,
	input  logic signed [KEY_W-1:0] key,
	output logic                    rsp_valid,
	input  logic                    rsp_stall,
	output logic [STATUS_W-1:0]     status,
	output logic [SLOT_W-1:0]       slot,
	output logic [CNT_W-1:0]        stored_count
);

	localparam int CMP_W = (CNT_W > TS_W) ? CNT_W : TS_W;
	localparam int REM_W = CNT_W + 1;

	// Control registers
	logic [TS_W-1:0]   ts_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SLOT_W-1:0] clr_q;
	logic [STEP_W-1:0] step_q;
	logic              rsp_valid_q;

	// Working registers
	logic              op_q;
	logic [KEY_W-1:0]  key_q;
	logic [KEY_W-1:0]  hash_q;
	logic [SLOT_W-1:0] idx_q;
	logic [SLOT_W-1:0] start_q;
	logic              coll_q;
	logic [STATUS_W-1:0] fin_status_q;
	logic [SLOT_W-1:0]   fin_slot_q;
	logic [STATUS_W-1:0] status_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [CNT_W-1:0]    count_q;

	// Key store
	logic [KEY_W-1:0]  mem_q [CAPACITY];
	logic [KEY_W-1:0]  rd_data_q;
	logic              mem_we;
	logic [SLOT_W-1:0] mem_waddr;
	logic [KEY_W-1:0]  mem_wdata;

	logic [CNT_W-1:0]  size_eff;
	logic [CMP_W-1:0]  ts_ext;
	logic [KEY_W-1:0]  hash_sum;
	logic [KEY_W-1:0]  hash_next;
	logic [REM_W-1:0]  rem_acc;
	logic [SLOT_W-1:0] rem_next;
	logic [CNT_W-1:0]  idx_inc;
	logic [SLOT_W-1:0] idx_adv;
	logic              slot_empty;
	logic              slot_match;
	logic              wrapped;
	logic              store_now;

	// Effective size, clamped to [2, CAPACITY]
	always_comb begin
		ts_ext = CMP_W'(ts_q);
		if (ts_ext < CMP_W'(2)) begin
			size_eff = CNT_W'(2);
		end else if (ts_ext > CMP_W'(CAPACITY)) begin
			size_eff = CNT_W'(CAPACITY);
		end else begin
			size_eff = CNT_W'(ts_ext);
		end
	end

	// One hash round: shift-add, fold top nibble into bits 7:4, clear it
	always_comb begin
		hash_sum  = {hash_q[KEY_W-5:0], 4'b0000} + key_q;
		hash_next = {4'b0000, hash_sum[KEY_W-5:8],
			hash_sum[7:4] ^ hash_sum[KEY_W-1:KEY_W-4], hash_sum[3:0]};
	end

	// Four restoring remainder steps, hash bits taken MSB first
	always_comb begin
		rem_acc = REM_W'(idx_q);
		for (int i = 0; i < MOD_DIGIT; i++) begin
			rem_acc = {rem_acc[REM_W-2:0], hash_q[HASH_W-1-i]};
			if (rem_acc >= REM_W'(size_eff)) rem_acc = rem_acc - REM_W'(size_eff);
		end
		rem_next = SLOT_W'(rem_acc);
	end

	// Probe pointer advance with wraparound
	always_comb begin
		idx_inc = CNT_W'(idx_q) + CNT_W'(1);
		idx_adv = (idx_inc >= size_eff) ? '0 : SLOT_W'(idx_inc);
	end

	assign slot_empty = (rd_data_q == '0);
	assign slot_match = (rd_data_q == key_q);
	assign wrapped    = (idx_adv == start_q);
	assign store_now  = cmd.check && slot_empty && (op_q == OP_INSERT);

	// Status to controller
	always_comb begin
		stat.clear_done = (clr_q == SLOT_W'(CAPACITY - 1));
		stat.key_zero   = (key == '0);
		stat.hash_last  = (step_q == STEP_W'(HASH_ROUNDS - 1));
		stat.mod_last   = (step_q == STEP_W'(MOD_STEPS - 1));
		stat.probe_done = slot_empty || slot_match || wrapped;
		stat.out_free   = !rsp_valid_q || !rsp_stall;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q        <= TS_RESET;
			cnt_q       <= '0;
			clr_q       <= '0;
			step_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) ts_q <= cfg_wdata;
			if (cmd.clear_step) clr_q <= clr_q + SLOT_W'(1);
			if (store_now) cnt_q <= cnt_q + CNT_W'(1);
			if (cmd.load) begin
				step_q <= '0;
			end else if (cmd.hash_step) begin
				step_q <= stat.hash_last ? '0 : step_q + STEP_W'(1);
			end else if (cmd.mod_step) begin
				step_q <= stat.mod_last ? '0 : step_q + STEP_W'(1);
			end
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Request capture, hashing, remainder, probe state and result register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q       <= operation;
			key_q      <= key;
			hash_q     <= '0;
			idx_q      <= '0;
			fin_slot_q <= '0;
			if (key == '0) begin
				fin_status_q <= (operation == OP_INSERT) ? ST_DUPLICATE : ST_NOT_FOUND;
			end else begin
				fin_status_q <= (operation == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
			end
		end
		if (cmd.hash_step) hash_q <= hash_next;
		if (cmd.mod_step) begin
			hash_q <= {hash_q[KEY_W-1-MOD_DIGIT:0], {MOD_DIGIT{1'b0}}};
			idx_q  <= rem_next;
			if (stat.mod_last) begin
				start_q <= rem_next;
				coll_q  <= 1'b0;
			end
		end
		if (cmd.check) begin
			if (slot_empty) begin
				if (op_q == OP_INSERT) begin
					fin_status_q <= coll_q ? ST_STORED_COLL : ST_STORED;
					fin_slot_q   <= idx_q;
				end
			end else if (slot_match) begin
				fin_status_q <= (op_q == OP_INSERT) ? ST_DUPLICATE : ST_FOUND;
				fin_slot_q   <= idx_q;
			end else begin
				idx_q  <= idx_adv;
				coll_q <= 1'b1;
			end
		end
		if (cmd.emit) begin
			status_q <= fin_status_q;
			slot_q   <= fin_slot_q;
			count_q  <= cnt_q;
		end
	end

	// Store write: clearing pass or insert
	always_comb begin
		mem_we    = cmd.clear_step || store_now;
		mem_waddr = cmd.clear_step ? clr_q : idx_q;
		mem_wdata = cmd.clear_step ? '0 : key_q;
	end

	// Store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_waddr] <= mem_wdata;
		if (cmd.rd) rd_data_q <= mem_q[idx_q];
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = status_q;
	assign slot         = slot_q;
	assign stored_count = count_q;

endmodule

[hdl/linear_probing_hash_table.sv]
// ----------------------------------------------------------------------------
// linear_probing_hash_table: open-addressed integer set, linear probing
//
//   channel   handshake            payload
//   request   req_valid/req_stall  operation, key
//   response  rsp_valid/rsp_stall  status, slot, stored_count
//   config    cfg_wen              cfg_wdata (table_size)
//
// A request with a nonzero key passes through capture, the hash rounds and
// the remainder steps, then per slot probed a registered store read and a
// compare, then a result state. A zero key goes from capture straight to
// the result state. After reset a clearing pass writes every slot, with
// requests stalled. A stalled response holds; the next request is taken
// meanwhile and waits in its result state until the register frees.
// ----------------------------------------------------------------------------
module linear_probing_hash_table import lpht_pkg::*; #(
	parameter int CAPACITY = LPHT_CAPACITY,
	localparam int SLOT_W  = $clog2(CAPACITY),
	localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wen,
	input  logic [TS_W-1:0]         cfg_wdata,
	input  logic                    req_valid,
	output logic                    req_stall,
	input  logic                    operation,
	input  logic signed [KEY_W-1:0] key,
	output logic                    rsp_valid,
	input  logic                    rsp_stall,
	output logic [STATUS_W-1:0]     status,
	output logic [SLOT_W-1:0]       slot,
	output logic [CNT_W-1:0]        stored_count
);

	lpht_cmd_t  cmd;
	lpht_stat_t stat;

	// Controller
	lpht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Datapath
	lpht_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.operation    (operation),
		.key          (key),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.status       (status),
		.slot         (slot),
		.stored_count (stored_count)
	);

endmodule
